// ===== rtl/sab_pkg.sv =====
package sab_pkg;

   // default build parameters
   localparam int DEF_MAX_TEXT = 1024;
   localparam int DEF_ALPHABET = 26;

   // fixed field widths
   localparam int SYM_W    = 5;
   localparam int RUN_W    = 20;
   localparam int STATES_W = 12;
   localparam int BYTE_W   = 8;
   localparam int RSP_W    = 40;

   // character codes for case folding
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;

   // operation codes
   localparam logic OP_EXTEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic             ok;
      logic [SYM_W-1:0] col;
   } fold_type;

   // request handed from the front end to the core
   typedef struct packed {
      logic             op;
      logic             first;
      logic             col_ok;
      logic [SYM_W-1:0] col;
   } start_type;

   // status handed back when a request is finished
   typedef struct packed {
      logic                full;
      logic                found;
      logic [STATES_W-1:0] states;
      logic [RUN_W-1:0]    distinct;
   } done_type;

   // shared adder and compare
   typedef struct packed {
      logic             sub;
      logic [RUN_W-1:0] a;
      logic [RUN_W-1:0] b;
      logic [RUN_W-1:0] cmp;
   } alu_req_type;

   typedef struct packed {
      logic [RUN_W-1:0] res;
      logic             eq;
   } alu_rsp_type;

   // fold a raw byte onto 0..25
   function automatic fold_type fold_byte(input logic [BYTE_W-1:0] b);
      fold_type f;
      logic [BYTE_W-1:0] d;
      f = '0;
      d = '0;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
         d = b - CH_UPPER_A;
         f.ok = 1'b1;
      end else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
         d = b - CH_LOWER_A;
         f.ok = 1'b1;
      end
      f.col = d[SYM_W-1:0];
      return f;
   endfunction

endpackage

// ===== rtl/sab_ram.sv =====
module sab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/sab_alu.sv =====
module sab_alu (
   input  sab_pkg::alu_req_type req,
   output sab_pkg::alu_rsp_type rsp
);
   import sab_pkg::*;

   logic [RUN_W-1:0] sum;

   // add or subtract, then compare against the third operand
   always_comb begin
      sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
      rsp.res = sum;
      rsp.eq  = (sum == req.cmp);
   end

endmodule

// ===== rtl/sab_core.sv =====
module sab_core #(
   parameter int MAX_TEXT = 1024,
   parameter int ALPHABET = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_valid,
   output logic               start_ready,
   input  sab_pkg::start_type start,
   output logic               done_valid,
   input  logic               done_ready,
   output sab_pkg::done_type  done
);
   import sab_pkg::*;

   localparam int NSTATES = 2 * MAX_TEXT + 1;
   localparam int SW      = $clog2(NSTATES);
   localparam int LW      = $clog2(MAX_TEXT + 1);
   localparam int TDEPTH  = NSTATES * (2 ** SYM_W);
   localparam int TAW     = $clog2(TDEPTH);
   localparam logic [SYM_W-1:0] COL_LAST = SYM_W'(ALPHABET - 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_QRY  = 5'd1;
   localparam logic [4:0] S_XQ   = 5'd2;
   localparam logic [4:0] S_XQL  = 5'd3;
   localparam logic [4:0] S_CLR  = 5'd4;
   localparam logic [4:0] S_WRD  = 5'd5;
   localparam logic [4:0] S_WCHK = 5'd6;
   localparam logic [4:0] S_FLP  = 5'd7;
   localparam logic [4:0] S_FLQ  = 5'd8;
   localparam logic [4:0] S_SCP  = 5'd9;
   localparam logic [4:0] S_SLNK = 5'd10;
   localparam logic [4:0] S_SCHK = 5'd11;
   localparam logic [4:0] S_SLK2 = 5'd12;
   localparam logic [4:0] S_SFIN = 5'd13;
   localparam logic [4:0] S_CNT1 = 5'd14;
   localparam logic [4:0] S_CNT2 = 5'd15;
   localparam logic [4:0] S_DONE = 5'd16;
   localparam logic [4:0] S_WLK  = 5'd17;

   logic [4:0]             st_ff, st_in;
   logic [SYM_W-1:0]       col_ff, col_in;
   logic [SYM_W-1:0]       k_ff, k_in;
   logic [SW-1:0]          qstate_ff, qstate_in;
   logic                   qlive_ff, qlive_in;
   logic [SW-1:0]          end_ff, end_in;
   logic [SW-1:0]          total_ff, total_in;
   logic [LW-1:0]          letters_ff, letters_in;
   logic [RUN_W-1:0]       running_ff, running_in;
   logic                   full_ff, full_in;
   logic [LW-1:0]          lenlast_ff, lenlast_in;
   logic [LW-1:0]          lencur_ff, lencur_in;
   logic [LW-1:0]          lenp_ff, lenp_in;
   logic [SW-1:0]          q_ff, q_in;
   logic [SW-1:0]          cur_ff, cur_in;
   logic [SW-1:0]          p_ff, p_in;
   logic [SW-1:0]          cl_ff, cl_in;
   logic [RUN_W-1:0]       diff_ff, diff_in;
   logic                   direct_ff, direct_in;
   logic [2**SYM_W-1:0]    root_vld_ff, root_vld_in;
   logic                   trz_ff, trz_in;
   logic                   lz_ff, lz_in;

   logic                   tr_we, tr_re;
   logic [TAW-1:0]         tr_waddr, tr_raddr;
   logic [SW-1:0]          tr_wdata, tr_rdata, tr_q;
   logic                   len_we, len_re;
   logic [SW-1:0]          len_waddr, len_raddr;
   logic [LW-1:0]          len_wdata, len_rdata, len_q;
   logic                   lnk_we, lnk_re;
   logic [SW-1:0]          lnk_waddr, lnk_raddr;
   logic [SW-1:0]          lnk_wdata, lnk_rdata;

   alu_req_type            alu_req;
   alu_rsp_type            alu_rsp;

   sab_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // transitions, one row of 2**SYM_W entries per state
   sab_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_tr_ram (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_waddr),
      .wr_data (tr_wdata),
      .rd_en   (tr_re),
      .rd_addr (tr_raddr),
      .rd_data (tr_rdata)
   );

   sab_ram #(.WIDTH(LW), .DEPTH(NSTATES)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   sab_ram #(.WIDTH(SW), .DEPTH(NSTATES)) u_lnk_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_en   (lnk_re),
      .rd_addr (lnk_raddr),
      .rd_data (lnk_rdata)
   );

   // root row entries never written read as none, root length reads as zero
   assign tr_q  = trz_ff ? '0 : tr_rdata;
   assign len_q = lz_ff ? '0 : len_rdata;

   assign start_ready = (st_ff == S_IDLE);
   assign done_valid  = (st_ff == S_DONE);

   always_comb begin
      done.full     = full_ff;
      done.found    = qlive_ff;
      done.states   = STATES_W'(total_ff);
      done.distinct = running_ff;
   end

   // sequencer
   always_comb begin
      logic [SW-1:0] qs;
      logic          lv;
      qs          = '0;
      lv          = 1'b0;
      st_in       = st_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      qstate_in   = qstate_ff;
      qlive_in    = qlive_ff;
      end_in      = end_ff;
      total_in    = total_ff;
      letters_in  = letters_ff;
      running_in  = running_ff;
      full_in     = full_ff;
      lenlast_in  = lenlast_ff;
      lencur_in   = lencur_ff;
      lenp_in     = lenp_ff;
      q_in        = q_ff;
      cur_in      = cur_ff;
      p_in        = p_ff;
      cl_in       = cl_ff;
      diff_in     = diff_ff;
      direct_in   = direct_ff;
      root_vld_in = root_vld_ff;
      trz_in      = trz_ff;
      lz_in       = lz_ff;
      tr_we       = 1'b0;
      tr_waddr    = '0;
      tr_wdata    = '0;
      tr_re       = 1'b0;
      tr_raddr    = '0;
      len_we      = 1'b0;
      len_waddr   = '0;
      len_wdata   = '0;
      len_re      = 1'b0;
      len_raddr   = '0;
      lnk_we      = 1'b0;
      lnk_waddr   = '0;
      lnk_wdata   = '0;
      lnk_re      = 1'b0;
      lnk_raddr   = '0;
      alu_req     = '0;

      unique case (st_ff)
         S_IDLE: begin
            if (start_valid) begin
               col_in  = start.col;
               full_in = 1'b0;
               if (start.op == OP_QUERY) begin
                  qs        = start.first ? '0 : qstate_ff;
                  lv        = start.first ? 1'b1 : qlive_ff;
                  qstate_in = qs;
                  qlive_in  = lv && start.col_ok;
                  st_in     = S_DONE;
                  if (lv && start.col_ok) begin
                     tr_re    = 1'b1;
                     tr_raddr = TAW'({qs, start.col});
                     trz_in   = (qs == '0) && !root_vld_ff[start.col];
                     st_in    = S_QRY;
                  end
               end else if (!start.col_ok) begin
                  end_in = '0;
                  st_in  = S_DONE;
               end else if (letters_ff >= LW'(MAX_TEXT)) begin
                  full_in = 1'b1;
                  st_in   = S_DONE;
               end else begin
                  letters_in = letters_ff + 1'b1;
                  tr_re      = 1'b1;
                  tr_raddr   = TAW'({end_ff, start.col});
                  trz_in     = (end_ff == '0) && !root_vld_ff[start.col];
                  len_re     = 1'b1;
                  len_raddr  = end_ff;
                  lz_in      = (end_ff == '0);
                  st_in      = S_XQ;
               end
            end
         end
         // query transition returned
         S_QRY: begin
            if (tr_q == '0) begin
               qlive_in = 1'b0;
            end else begin
               qstate_in = tr_q;
            end
            st_in = S_DONE;
         end
         // transition and length of the end state returned
         S_XQ: begin
            q_in       = tr_q;
            lenlast_in = len_q;
            p_in       = end_ff;
            if (tr_q != '0) begin
               len_re    = 1'b1;
               len_raddr = tr_q;
               lz_in     = 1'b0;
               st_in     = S_XQL;
            end else begin
               alu_req.a = RUN_W'(len_q);
               alu_req.b = RUN_W'(1);
               cur_in    = total_ff;
               total_in  = total_ff + 1'b1;
               lencur_in = LW'(alu_rsp.res);
               len_we    = 1'b1;
               len_waddr = total_ff;
               len_wdata = LW'(alu_rsp.res);
               k_in      = '0;
               st_in     = S_CLR;
            end
         end
         // existing transition: reuse or split
         S_XQL: begin
            alu_req.a   = RUN_W'(lenlast_ff);
            alu_req.b   = RUN_W'(1);
            alu_req.cmp = RUN_W'(len_q);
            if (alu_rsp.eq) begin
               end_in = q_ff;
               st_in  = S_DONE;
            end else begin
               direct_in = 1'b1;
               lenp_in   = lenlast_ff;
               cl_in     = total_ff;
               total_in  = total_ff + 1'b1;
               len_we    = 1'b1;
               len_waddr = total_ff;
               len_wdata = LW'(alu_rsp.res);
               k_in      = '0;
               tr_re     = 1'b1;
               tr_raddr  = TAW'({q_ff, {SYM_W{1'b0}}});
               trz_in    = 1'b0;
               st_in     = S_SCP;
            end
         end
         // clear the new state's row
         S_CLR: begin
            tr_we    = 1'b1;
            tr_waddr = TAW'({cur_ff, k_ff});
            tr_wdata = '0;
            k_in     = k_ff + 1'b1;
            if (k_ff == COL_LAST) begin
               st_in = S_WRD;
            end
         end
         S_WRD: begin
            tr_re    = 1'b1;
            tr_raddr = TAW'({p_ff, col_ff});
            trz_in   = (p_ff == '0) && !root_vld_ff[col_ff];
            st_in    = S_WCHK;
         end
         // suffix link walk, adding edges to the new state
         S_WCHK: begin
            if (tr_q != '0) begin
               q_in      = tr_q;
               len_re    = 1'b1;
               len_raddr = p_ff;
               lz_in     = (p_ff == '0);
               st_in     = S_FLP;
            end else begin
               tr_we    = 1'b1;
               tr_waddr = TAW'({p_ff, col_ff});
               tr_wdata = cur_ff;
               if (p_ff == '0) begin
                  root_vld_in[col_ff] = 1'b1;
                  lnk_we    = 1'b1;
                  lnk_waddr = cur_ff;
                  lnk_wdata = '0;
                  len_re    = 1'b1;
                  len_raddr = '0;
                  lz_in     = 1'b1;
                  st_in     = S_CNT1;
               end else begin
                  lnk_re    = 1'b1;
                  lnk_raddr = p_ff;
                  st_in     = S_WLK;
               end
            end
         end
         // follow the suffix link of a non-root state
         S_WLK: begin
            p_in     = lnk_rdata;
            tr_re    = 1'b1;
            tr_raddr = TAW'({lnk_rdata, col_ff});
            trz_in   = (lnk_rdata == '0) && !root_vld_ff[col_ff];
            st_in    = S_WCHK;
         end
         S_FLP: begin
            lenp_in   = len_q;
            len_re    = 1'b1;
            len_raddr = q_ff;
            lz_in     = 1'b0;
            st_in     = S_FLQ;
         end
         S_FLQ: begin
            alu_req.a   = RUN_W'(lenp_ff);
            alu_req.b   = RUN_W'(1);
            alu_req.cmp = RUN_W'(len_q);
            if (alu_rsp.eq) begin
               lnk_we    = 1'b1;
               lnk_waddr = cur_ff;
               lnk_wdata = q_ff;
               len_re    = 1'b1;
               len_raddr = q_ff;
               lz_in     = 1'b0;
               st_in     = S_CNT1;
            end else begin
               direct_in = 1'b0;
               cl_in     = total_ff;
               total_in  = total_ff + 1'b1;
               len_we    = 1'b1;
               len_waddr = total_ff;
               len_wdata = LW'(alu_rsp.res);
               k_in      = '0;
               tr_re     = 1'b1;
               tr_raddr  = TAW'({q_ff, {SYM_W{1'b0}}});
               trz_in    = 1'b0;
               st_in     = S_SCP;
            end
         end
         // copy the split state's row into the clone, read one ahead
         S_SCP: begin
            tr_we    = 1'b1;
            tr_waddr = TAW'({cl_ff, k_ff});
            tr_wdata = tr_q;
            if (k_ff == COL_LAST) begin
               lnk_re    = 1'b1;
               lnk_raddr = q_ff;
               st_in     = S_SLNK;
            end else begin
               tr_re    = 1'b1;
               tr_raddr = TAW'({q_ff, k_ff + 1'b1});
               trz_in   = 1'b0;
               k_in     = k_ff + 1'b1;
            end
         end
         S_SLNK: begin
            lnk_we    = 1'b1;
            lnk_waddr = cl_ff;
            lnk_wdata = lnk_rdata;
            tr_re     = 1'b1;
            tr_raddr  = TAW'({p_ff, col_ff});
            trz_in    = (p_ff == '0) && !root_vld_ff[col_ff];
            st_in     = S_SCHK;
         end
         // redirect edges that pointed at the split state
         S_SCHK: begin
            if (tr_q == q_ff) begin
               tr_we    = 1'b1;
               tr_waddr = TAW'({p_ff, col_ff});
               tr_wdata = cl_ff;
               if (p_ff == '0) begin
                  root_vld_in[col_ff] = 1'b1;
               end
            end
            if (tr_q != q_ff || p_ff == '0) begin
               lnk_we    = 1'b1;
               lnk_waddr = q_ff;
               lnk_wdata = cl_ff;
               if (direct_ff) begin
                  end_in = cl_ff;
                  st_in  = S_DONE;
               end else begin
                  st_in = S_SFIN;
               end
            end else begin
               lnk_re    = 1'b1;
               lnk_raddr = p_ff;
               st_in     = S_SLK2;
            end
         end
         S_SLK2: begin
            p_in     = lnk_rdata;
            tr_re    = 1'b1;
            tr_raddr = TAW'({lnk_rdata, col_ff});
            trz_in   = (lnk_rdata == '0) && !root_vld_ff[col_ff];
            st_in    = S_SCHK;
         end
         S_SFIN: begin
            lnk_we    = 1'b1;
            lnk_waddr = cur_ff;
            lnk_wdata = cl_ff;
            len_re    = 1'b1;
            len_raddr = cl_ff;
            lz_in     = 1'b0;
            st_in     = S_CNT1;
         end
         // count update: length of new state minus length of its link
         S_CNT1: begin
            alu_req.sub = 1'b1;
            alu_req.a   = RUN_W'(lencur_ff);
            alu_req.b   = RUN_W'(len_q);
            diff_in     = alu_rsp.res;
            st_in       = S_CNT2;
         end
         S_CNT2: begin
            alu_req.a  = running_ff;
            alu_req.b  = diff_ff;
            running_in = alu_rsp.res;
            end_in     = cur_ff;
            st_in      = S_DONE;
         end
         S_DONE: begin
            if (done_ready) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         qstate_ff   <= '0;
         qlive_ff    <= 1'b1;
         end_ff      <= '0;
         total_ff    <= SW'(1);
         letters_ff  <= '0;
         running_ff  <= '0;
         full_ff     <= 1'b0;
         root_vld_ff <= '0;
      end else begin
         st_ff       <= st_in;
         qstate_ff   <= qstate_in;
         qlive_ff    <= qlive_in;
         end_ff      <= end_in;
         total_ff    <= total_in;
         letters_ff  <= letters_in;
         running_ff  <= running_in;
         full_ff     <= full_in;
         root_vld_ff <= root_vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      k_ff       <= k_in;
      lenlast_ff <= lenlast_in;
      lencur_ff  <= lencur_in;
      lenp_ff    <= lenp_in;
      q_ff       <= q_in;
      cur_ff     <= cur_in;
      p_ff       <= p_in;
      cl_ff      <= cl_in;
      diff_ff    <= diff_in;
      direct_ff  <= direct_in;
      trz_ff     <= trz_in;
      lz_ff      <= lz_in;
   end

endmodule

// ===== rtl/suffix_automaton_builder.sv =====
// per request: a query reads one transition; a letter reusing an existing state checks its length; a letter
// adding a state clears its row, then walks suffix links until an existing edge or the root; a split
// copies the split state's row into the clone and redirects the edges that pointed at the split state
// throughput: one request at a time; a result waits in an output register meanwhile
// reset: synchronous, active high; root state only, no memory clearing pass
module suffix_automaton_builder #(
   parameter int MAX_TEXT = sab_pkg::DEF_MAX_TEXT,
   parameter int ALPHABET = sab_pkg::DEF_ALPHABET
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sab_pkg::BYTE_W-1:0] req_tdata,  // symbol
   input  logic [1:0]                req_tuser,  // operation, first
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sab_pkg::RSP_W-1:0] rsp_tdata   // distinct_count, states_used,
                                                 // pattern_found, store_full
);
   import sab_pkg::*;

   fold_type   fold;
   start_type  start;
   logic       start_ready;
   logic       done_valid;
   logic       done_ready;
   done_type   done;
   logic       rsp_valid_ff, rsp_valid_in;
   done_type   rsp_ff, rsp_in;

   // fold the raw byte, letters past the alphabet count as non-letters
   always_comb begin
      fold         = fold_byte(req_tdata);
      start.op     = req_tuser[0];
      start.first  = req_tuser[1];
      start.col    = fold.col;
      start.col_ok = fold.ok && (int'(fold.col) < ALPHABET);
   end

   sab_core #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_core (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_tvalid),
      .start_ready (start_ready),
      .start       (start),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done        (done)
   );

   assign req_tready = start_ready;
   assign done_ready = !rsp_valid_ff || rsp_tready;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_ff.full, rsp_ff.found, rsp_ff.states, rsp_ff.distinct});

endmodule

// ===== verif/suffix_automaton_builder_tb.sv =====
module suffix_automaton_builder_tb;
   import sab_pkg::*;

   localparam int TEXT_LIMIT = DEF_MAX_TEXT;
   localparam int LETTERS    = DEF_ALPHABET;
   localparam int NODES      = 2 * TEXT_LIMIT + 1;
   localparam int CYCLE_CAP  = 3_000_000;

   // one response word, lowest field last
   typedef struct packed {
      logic          full;
      logic          found;
      logic [11:0]   states;
      logic [19:0]   distinct;
   } answer_type;

   typedef struct {
      logic       op;
      logic [7:0] sym;
      logic       first;
      bit         typed;
      answer_type ans;
   } row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata;   // symbol
   logic [1:0]        req_tuser;   // operation, first
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // distinct_count, states_used, pattern_found, store_full

   suffix_automaton_builder DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // automaton mirror
   int node_len  [NODES];
   int node_link [NODES];
   int node_next [NODES][LETTERS];
   int node_count;
   int tail_node;
   int probe_node;
   bit probe_live;
   int substr_total;
   int letters_used;

   answer_type pending_answers[$];
   int         mismatches;
   int         tx_idle;
   int         rx_idle;
   int         cycles;
   logic [7:0] text_hist[$];

   function automatic int fold_letter(logic [7:0] b);
      int v;
      v = -1;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) v = int'(b - CH_UPPER_A);
      else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) v = int'(b - CH_LOWER_A);
      if (v >= LETTERS) v = -1;
      return v;
   endfunction

   // clone q as seen from p on letter c, redirect p's chain
   function automatic int split_node(int p, int q, int c);
      int cl;
      cl = node_count;
      node_count++;
      for (int k = 0; k < LETTERS; k++) node_next[cl][k] = node_next[q][k];
      node_link[cl] = node_link[q];
      node_len[cl]  = node_len[p] + 1;
      forever begin
         if (node_next[p][c] != q) break;
         node_next[p][c] = cl;
         if (p == 0) break;
         p = node_link[p];
      end
      node_link[q] = cl;
      return cl;
   endfunction

   function automatic void grow_automaton(int c);
      int q, cur, p;
      bit off_root;
      off_root = 0;
      q = node_next[tail_node][c];
      if (q != 0) begin
         if (node_len[q] == node_len[tail_node] + 1) tail_node = q;
         else tail_node = split_node(tail_node, q, c);
         return;
      end
      cur = node_count;
      node_count++;
      for (int k = 0; k < LETTERS; k++) node_next[cur][k] = 0;
      node_len[cur] = node_len[tail_node] + 1;
      p = tail_node;
      forever begin
         if (node_next[p][c] != 0) break;
         node_next[p][c] = cur;
         if (p == 0) begin
            off_root = 1;
            break;
         end
         p = node_link[p];
      end
      if (off_root) node_link[cur] = 0;
      else begin
         q = node_next[p][c];
         if (node_len[p] + 1 == node_len[q]) node_link[cur] = q;
         else node_link[cur] = split_node(p, q, c);
      end
      substr_total += node_len[cur] - node_len[node_link[cur]];
      tail_node = cur;
   endfunction

   function automatic answer_type predict_answer(logic op, logic [7:0] sym, logic first);
      answer_type a;
      int c;
      bit rejected;
      c = fold_letter(sym);
      rejected = 0;
      if (op == OP_EXTEND) begin
         if (c < 0) tail_node = 0;
         else if (letters_used >= TEXT_LIMIT) rejected = 1;
         else begin
            letters_used++;
            grow_automaton(c);
         end
      end else begin
         if (first) begin
            probe_node = 0;
            probe_live = 1;
         end
         if (probe_live) begin
            if (c < 0 || node_next[probe_node][c] == 0) probe_live = 0;
            else probe_node = node_next[probe_node][c];
         end
      end
      a.distinct = substr_total[19:0];
      a.states   = node_count[11:0];
      a.found    = probe_live;
      a.full     = rejected;
      return a;
   endfunction

   task automatic send_request(logic op, logic [7:0] sym, logic first, bit typed,
                               answer_type ta);
      answer_type a;
      if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= {first, op};
      do @(posedge clock); while (!req_tready);
      a = predict_answer(op, sym, first);
      if (op == OP_EXTEND && fold_letter(sym) >= 0) text_hist.insert(text_hist.size(), sym);
      pending_answers.insert(pending_answers.size(), typed ? ta : a);
   endtask

   function automatic logic [7:0] letter_byte(int c);
      return 8'(($urandom_range(1) ? int'(CH_UPPER_A) : int'(CH_LOWER_A)) + c);
   endfunction

   // mostly real text and substring queries, some noise
   task automatic random_requests(int n);
      int sent, kind, len, start;
      answer_type none;
      none = '0;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            send_request(OP_EXTEND, letter_byte(int'($urandom_range(3))),
                         1'($urandom_range(1)), 1'b0, none);
            sent++;
         end else if (kind < 80 && text_hist.size() > 0) begin
            len = $urandom_range(1, 6);
            start = $urandom_range(text_hist.size() - 1);
            for (int k = 0; k < len && start + k < text_hist.size(); k++) begin
               logic [7:0] b;
               b = text_hist[start + k];
               if ($urandom_range(9) == 0) b = letter_byte(int'($urandom_range(LETTERS - 1)));
               else b = letter_byte(fold_letter(b));
               send_request(OP_QUERY, b, k == 0, 1'b0, none);
               sent++;
            end
         end else begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'b0, none);
            sent++;
         end
      end
   endtask

   row_type plan[$];

   function automatic row_type mk(logic op, logic [7:0] sym, logic first, bit typed,
                                  int d, int s, logic f);
      row_type r;
      r.op = op; r.sym = sym; r.first = first; r.typed = typed;
      r.ans = '{full: 1'b0, found: f, states: s[11:0], distinct: d[19:0]};
      return r;
   endfunction

   // response checker and cycle watchdog
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_CAP) begin
            $display("suffix_automaton_builder_tb failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[33:0];
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               want = pending_answers.pop_front();
               if (got.distinct !== want.distinct || got.states !== want.states ||
                   got.found !== want.found || got.full !== want.full) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: want d=%0d s=%0d f=%b full=%b got d=%0d s=%0d f=%b full=%b",
                              want.distinct, want.states, want.found, want.full,
                              got.distinct, got.states, got.found, got.full);
               end
            end
         end
      end
      rsp_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
   end

   initial begin
      answer_type none;
      none = '0;
      cycles = 0;
      mismatches = 0;
      tx_idle = 0;
      rx_idle = 0;
      for (int n = 0; n < NODES; n++) begin
         node_len[n] = 0;
         node_link[n] = 0;
         for (int k = 0; k < LETTERS; k++) node_next[n][k] = 0;
      end
      node_count = 1; tail_node = 0; probe_node = 0; probe_live = 1;
      substr_total = 0; letters_used = 0;
      clock      <= 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, byte extremes, repeats after a separator, dead queries
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h40, 1'b0, 1'b1, 0, 1, 1'b1));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h61, 1'b1, 1'b1, 0, 1, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h41, 1'b0, 1'b1, 1, 2, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h7A, 1'b0, 1'b1, 3, 3, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h62, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h61, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h42, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h7B, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h62, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h41, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h5A, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h5B, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h7A, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h61, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h42, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h63, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h60, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h61, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h5A, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'hFF, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_QUERY,  8'h00, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'hFF, 1'b1, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h00, 1'b0, 1'b0, 0, 0, 1'b0));
      plan.insert(plan.size(), mk(OP_EXTEND, 8'h7A, 1'b0, 1'b0, 0, 0, 1'b0));
      foreach (plan[i]) send_request(plan[i].op, plan[i].sym, plan[i].first,
                                     plan[i].typed, plan[i].ans);

      tx_idle = 13; rx_idle = 83;
      random_requests(140);
      tx_idle = 83; rx_idle = 13;
      random_requests(140);
      tx_idle = 0; rx_idle = 0;
      random_requests(140);

      // letters, a separator and a query at the end of the text
      send_request(OP_EXTEND, 8'h41, 1'b0, 1'b0, none);
      send_request(OP_EXTEND, 8'h7A, 1'b1, 1'b0, none);
      send_request(OP_EXTEND, 8'h20, 1'b0, 1'b0, none);
      send_request(OP_EXTEND, 8'h62, 1'b0, 1'b0, none);
      send_request(OP_QUERY,  8'h61, 1'b1, 1'b0, none);
      send_request(OP_QUERY,  8'h62, 1'b0, 1'b0, none);
      req_tvalid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("suffix_automaton_builder_tb passed");
      else $display("suffix_automaton_builder_tb failed");
      $finish;
   end

endmodule

// ===== suffix_automaton_builder.f =====
rtl/sab_pkg.sv
rtl/sab_ram.sv
rtl/sab_alu.sv
rtl/sab_core.sv
rtl/suffix_automaton_builder.sv
verif/suffix_automaton_builder_tb.sv
